// ----- rtl/rebq_pkg.sv -----
// Shared types, constants and the quadrature lookup for the rotary encoder block.
// No dependencies; every other file refers into it by scoped names.
package rebq_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_GAP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_CLICK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL  = 3'd4;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    // One classified sample, as it travels from front to back
    typedef struct packed {
        dir_t dir;
        logic pin;
        logic tick;
    } item_t;

    typedef struct packed {
        logic [15:0] min_step_gap;
        logic [4:0]  steps_click;
        logic [15:0] long_press;
        logic [15:0] debounce;
        logic        press_level;
    } cfg_t;

    typedef struct packed {
        logic       any_event;
        logic       long_press;
        logic       released;
        logic       pressed;
        logic [5:0] steps;
    } result_t;

    // Quadrature transition table, index is previous phase * 4 + current phase
    function automatic dir_t quad_dir(input logic [1:0] prev, input logic [1:0] cur);
        dir_t d;
        unique case ({prev, cur})
            4'd1, 4'd7, 4'd8, 4'd14: d = DIR_CCW;
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_CW;
            default: d = DIR_NONE;
        endcase
        return d;
    endfunction

    function automatic count_t sat_inc(input count_t c);
        return (c == CNT_MAX) ? c : c + count_t'(1);
    endfunction

endpackage

// ----- rtl/rebq_front.sv -----
// Front end: accepts pin samples, tracks the encoder phase and classifies each
// transition into a direction. Depends on rebq_pkg.
module rebq_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             clk_line,
    input  logic             dt_line,
    input  logic             switch_pin,
    input  logic             ms_tick,
    input  logic             q_full,
    output logic             in_ready,
    output logic             push,
    output rebq_pkg::item_t  push_item
);

    logic [1:0] prev_phase_reg;
    logic [1:0] prev_phase_next;
    logic [1:0] cur_phase;

    assign cur_phase = {dt_line, clk_line};
    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;

    always_comb begin
        push_item.dir  = rebq_pkg::quad_dir(prev_phase_reg, cur_phase);
        push_item.pin  = switch_pin;
        push_item.tick = ms_tick;
        prev_phase_next = push ? cur_phase : prev_phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_phase_reg <= 2'd3;
        end else begin
            prev_phase_reg <= prev_phase_next;
        end
    end

endmodule

// ----- rtl/rebq_queue.sv -----
// Two-entry queue of classified samples between front and back.
// Depends on rebq_pkg.
module rebq_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rebq_pkg::item_t  push_item,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output rebq_pkg::item_t  head
);

    rebq_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/rebq_back.sv -----
// Back end: gap counters, step gating, switch debounce and long press detection,
// with the result register toward the output channel. Depends on rebq_pkg.
module rebq_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  rebq_pkg::cfg_t   cfg,
    input  logic             item_valid,
    input  rebq_pkg::item_t  item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output rebq_pkg::result_t out_data
);

    rebq_pkg::count_t step_gap_reg, step_gap_next;
    rebq_pkg::count_t edge_gap_reg, edge_gap_next;
    rebq_pkg::count_t held_cnt_reg, held_cnt_next;
    logic switch_level_reg, switch_level_next;
    logic switch_held_reg, switch_held_next;
    logic long_sent_reg, long_sent_next;
    logic out_valid_reg, out_valid_next;
    rebq_pkg::result_t result_reg, result_next;

    logic [5:0] mag;
    logic       take;

    assign take      = !out_valid_reg || out_ready;
    assign pop       = item_valid && take;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;
    assign mag       = {1'b0, cfg.steps_click};

    always_comb begin
        step_gap_next     = step_gap_reg;
        edge_gap_next     = edge_gap_reg;
        held_cnt_next     = held_cnt_reg;
        switch_level_next = switch_level_reg;
        switch_held_next  = switch_held_reg;
        long_sent_next    = long_sent_reg;
        result_next       = '0;

        if (item.tick) begin
            step_gap_next = rebq_pkg::sat_inc(step_gap_reg);
            edge_gap_next = rebq_pkg::sat_inc(edge_gap_reg);
            held_cnt_next = rebq_pkg::sat_inc(held_cnt_reg);
        end

        if (item.dir != rebq_pkg::DIR_NONE
                && 32'(step_gap_next) >= 32'(cfg.min_step_gap)) begin
            result_next.steps = (item.dir == rebq_pkg::DIR_CW) ? mag : (~mag + 6'd1);
            step_gap_next = '0;
        end

        if (item.pin != switch_level_reg && 32'(edge_gap_next) >= 32'(cfg.debounce)) begin
            edge_gap_next     = '0;
            switch_level_next = item.pin;
            if (item.pin == cfg.press_level) begin
                switch_held_next    = 1'b1;
                held_cnt_next       = '0;
                long_sent_next      = 1'b0;
                result_next.pressed = 1'b1;
            end else if (switch_held_reg) begin
                switch_held_next     = 1'b0;
                result_next.released = 1'b1;
            end
        end

        // fire the long press once per hold
        if (switch_held_next && !long_sent_next
                && 32'(held_cnt_next) >= 32'(cfg.long_press)) begin
            long_sent_next         = 1'b1;
            result_next.long_press = 1'b1;
        end

        result_next.any_event = (result_next.steps != 6'd0) || result_next.pressed
                                || result_next.released || result_next.long_press;

        out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_gap_reg     <= rebq_pkg::CNT_MAX;
            edge_gap_reg     <= rebq_pkg::CNT_MAX;
            held_cnt_reg     <= '0;
            switch_level_reg <= 1'b1;
            switch_held_reg  <= 1'b0;
            long_sent_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                step_gap_reg     <= step_gap_next;
                edge_gap_reg     <= edge_gap_next;
                held_cnt_reg     <= held_cnt_next;
                switch_level_reg <= switch_level_next;
                switch_held_reg  <= switch_held_next;
                long_sent_reg    <= long_sent_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- rtl/rotary_encoder_with_button_qualifier_top.sv -----
// Top level of the rotary encoder decoder with debounced push switch.
// Holds the configuration registers; depends on rebq_pkg, rebq_front,
// rebq_queue and rebq_back.
//
// Usage:
//   s_ channel: one sample per transfer of the encoder lines, the switch pin
//   and a millisecond tick flag. m_ channel: one result per sample with the
//   signed step count and the press, release and long press events.
//   cfg channel: register index and write data, always ready; write only
//   while no sample is in flight.
// Path: an accepted sample goes through the queue stage, then the result
//   register, before its result is shown on m_.
// Throughput: one sample per cycle while m_ is not stalled; the back end
//   decides a whole sample combinationally, and the two-entry queue lets
//   the front keep accepting while a result waits.
// Receiver stall: the result register holds; the back end stops popping,
//   the queue fills and s_tready drops once it holds two samples.
// Reset (aresetn low, synchronous): registers return to their defaults,
//   phase is both lines high, gap counters saturated, switch level high,
//   queue and result register empty.
module rotary_encoder_with_button_qualifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] clk_line, [1] dt_line, [2] switch_pin, [3] ms_tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] steps, [6] pressed, [7] released,
                                   // [8] long_press, [9] any_event
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rebq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rebq_pkg::CFG_W-1:0]     cfg_data
);

    rebq_pkg::cfg_t    cfg_reg;
    rebq_pkg::item_t   push_item;
    rebq_pkg::item_t   head;
    rebq_pkg::result_t result;
    logic push, pop, q_full, q_not_empty;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'd0, result};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_step_gap <= 16'd2;
            cfg_reg.steps_click  <= 5'd1;
            cfg_reg.long_press   <= 16'd1000;
            cfg_reg.debounce     <= 16'd50;
            cfg_reg.press_level  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rebq_pkg::REG_MIN_STEP_GAP: cfg_reg.min_step_gap <= cfg_data;
                rebq_pkg::REG_STEPS_CLICK:  cfg_reg.steps_click  <= cfg_data[4:0];
                rebq_pkg::REG_LONG_PRESS:   cfg_reg.long_press   <= cfg_data;
                rebq_pkg::REG_DEBOUNCE:     cfg_reg.debounce     <= cfg_data;
                rebq_pkg::REG_PRESS_LEVEL:  cfg_reg.press_level  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    rebq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .clk_line   (s_tdata[0]),
        .dt_line    (s_tdata[1]),
        .switch_pin (s_tdata[2]),
        .ms_tick    (s_tdata[3]),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_item  (push_item)
    );

    rebq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    rebq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (q_not_empty),
        .item       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (result)
    );

endmodule

// ----- tb/sv/rebq_checker.sv -----
// Checker for the rotary encoder block: watches the sample, result and register channels.
// Predicts each result from its own copy of the decoder state and compares field by field.
// Depends on rebq_pkg for the register indexes, the direction enum and the result layout.
module rebq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] clk_line, [1] dt_line, [2] switch_pin, [3] ms_tick
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [5:0] steps, [6] pressed, [7] released,
                                    // [8] long_press, [9] any_event
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [rebq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rebq_pkg::CFG_W-1:0]     cfg_data,
    output int          fail_count,
    output int          due_count,
    output int          checked_count,
    output int          step_count,
    output int          press_count,
    output int          long_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies
    logic [15:0] min_gap;
    logic [4:0]  click;
    logic [15:0] long_ms;
    logic [15:0] debounce;
    logic        press_lvl;

    // Decoder state
    logic [1:0]         last_phase;
    rebq_pkg::count_t   step_gap;
    logic               sw_level;
    logic               sw_held;
    rebq_pkg::count_t   held_ms;
    logic               long_done;
    rebq_pkg::count_t   level_gap;

    rebq_pkg::result_t  decoded_due[$];

    // Position of a phase on the clockwise ring 3 -> 1 -> 0 -> 2 -> 3
    function automatic int ring_pos(input logic [1:0] ph);
        case (ph)
            2'd3:    return 0;
            2'd1:    return 1;
            2'd0:    return 2;
            default: return 3;
        endcase
    endfunction

    function automatic rebq_pkg::dir_t turn_of(input logic [1:0] from_ph,
                                               input logic [1:0] to_ph);
        int ring_diff;
        ring_diff = (ring_pos(to_ph) - ring_pos(from_ph)) & 3;
        if (ring_diff == 1) return rebq_pkg::DIR_CW;
        if (ring_diff == 3) return rebq_pkg::DIR_CCW;
        return rebq_pkg::DIR_NONE;
    endfunction

    function automatic rebq_pkg::count_t bump(input rebq_pkg::count_t c);
        return (c == rebq_pkg::CNT_MAX) ? c : c + rebq_pkg::count_t'(1);
    endfunction

    task automatic decode_sample(input logic [7:0] smp, output rebq_pkg::result_t r);
        logic [1:0]     cur;
        logic           pin;
        rebq_pkg::dir_t dir;
        cur = smp[1:0];
        pin = smp[2];
        r   = '0;
        if (smp[3]) begin
            step_gap  = bump(step_gap);
            level_gap = bump(level_gap);
            held_ms   = bump(held_ms);
        end
        if (cur != last_phase) begin
            // a step inside the gap or a double jump keeps the gap running
            if (step_gap >= min_gap) begin
                dir = turn_of(last_phase, cur);
                if (dir == rebq_pkg::DIR_CW) begin
                    r.steps  = 6'(click);
                    step_gap = '0;
                end else if (dir == rebq_pkg::DIR_CCW) begin
                    r.steps  = 6'd0 - 6'(click);
                    step_gap = '0;
                end
            end
            last_phase = cur;
        end
        if (pin != sw_level && level_gap >= debounce) begin
            level_gap = '0;
            sw_level  = pin;
            if (pin == press_lvl) begin
                sw_held   = 1'b1;
                held_ms   = '0;
                long_done = 1'b0;
                r.pressed = 1'b1;
            end else if (sw_held) begin
                sw_held    = 1'b0;
                r.released = 1'b1;
            end
        end
        if (sw_held && !long_done && held_ms >= long_ms) begin
            long_done    = 1'b1;
            r.long_press = 1'b1;
        end
        r.any_event = (r.steps != 6'd0) || r.pressed || r.released || r.long_press;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count    = 0;
        due_count     = 0;
        checked_count = 0;
        step_count    = 0;
        press_count   = 0;
        long_count    = 0;
    end

    always @(posedge aclk) begin
        rebq_pkg::result_t want;
        rebq_pkg::result_t fresh;
        if (!aresetn) begin
            min_gap    = 16'd2;
            click      = 5'd1;
            long_ms    = 16'd1000;
            debounce   = 16'd50;
            press_lvl  = 1'b1;
            last_phase = 2'd3;
            step_gap   = rebq_pkg::CNT_MAX;
            sw_level   = 1'b1;
            sw_held    = 1'b0;
            held_ms    = '0;
            long_done  = 1'b0;
            level_gap  = rebq_pkg::CNT_MAX;
            decoded_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_due.size() == 0) begin
                    $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = decoded_due.pop_front();
                    check_field("steps", $signed(want.steps), $signed(m_tdata[5:0]));
                    check_field("pressed", want.pressed, m_tdata[6]);
                    check_field("released", want.released, m_tdata[7]);
                    check_field("long_press", want.long_press, m_tdata[8]);
                    check_field("any_event", want.any_event, m_tdata[9]);
                    check_field("padding", 0, m_tdata[15:10]);
                    checked_count++;
                    if (want.steps != 6'd0) step_count++;
                    if (want.pressed) press_count++;
                    if (want.long_press) long_count++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rebq_pkg::REG_MIN_STEP_GAP: min_gap   = cfg_data;
                    rebq_pkg::REG_STEPS_CLICK:  click     = cfg_data[4:0];
                    rebq_pkg::REG_LONG_PRESS:   long_ms   = cfg_data;
                    rebq_pkg::REG_DEBOUNCE:     debounce  = cfg_data;
                    rebq_pkg::REG_PRESS_LEVEL:  press_lvl = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_sample(s_tdata, fresh);
                decoded_due.push_back(fresh);
            end
        end
        due_count = decoded_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the rotary encoder block: clock, reset, sample and register stimulus.
// Drives directed then random encoder and switch samples; rebq_checker does the checking.
// Depends on rebq_pkg, rotary_encoder_with_button_qualifier_top and rebq_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 200000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [rebq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rebq_pkg::CFG_W-1:0]     cfg_data  = '0;

    int fail_count, due_count, checked_count, step_count, press_count, long_count;

    int   s_idle_pct  = 0;
    int   m_idle_pct  = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_left   = 0;
    int   cycles      = 0;
    int   in_stalls   = 0;
    int   n_settings  = 1;

    // Random walk state of the knob and the switch
    logic [1:0] walk_ph   = 2'd3;
    logic       walk_cw   = 1'b1;
    logic       sw_target = 1'b1;

    rotary_encoder_with_button_qualifier_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rebq_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .checked_count (checked_count),
        .step_count    (step_count),
        .press_count   (press_count),
        .long_count    (long_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (s_tvalid && !s_tready) in_stalls++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, due_count);
            $display("** rotary_encoder_with_button_qualifier_top: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = STALL_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    function automatic logic [1:0] cw_next(input logic [1:0] ph);
        case (ph)
            2'd3:    return 2'd1;
            2'd1:    return 2'd0;
            2'd0:    return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    function automatic logic [1:0] ccw_next(input logic [1:0] ph);
        case (ph)
            2'd1:    return 2'd3;
            2'd0:    return 2'd1;
            2'd2:    return 2'd0;
            default: return 2'd2;
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge past the transfer
    task automatic send_sample(input logic [1:0] ph, input logic pin, input logic tick);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, tick, pin, ph[1], ph[0]};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (due_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [rebq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rebq_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [15:0] gap, input logic [4:0] per_click,
                             input logic [15:0] hold_ms, input logic [15:0] deb_ms,
                             input logic lvl);
        wait_drained();
        write_reg(rebq_pkg::REG_MIN_STEP_GAP, gap);
        write_reg(rebq_pkg::REG_STEPS_CLICK, rebq_pkg::CFG_W'(per_click));
        write_reg(rebq_pkg::REG_LONG_PRESS, hold_ms);
        write_reg(rebq_pkg::REG_DEBOUNCE, deb_ms);
        write_reg(rebq_pkg::REG_PRESS_LEVEL, rebq_pkg::CFG_W'(lvl));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mostly clean quadrature walks and held switch levels, with jumps and bounce mixed in
    task automatic random_samples(input int count, input int tick_pct);
        int   roll;
        logic pin;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if ($urandom_range(99) < 10) walk_cw = !walk_cw;
            if (roll < 45)
                walk_ph = walk_cw ? cw_next(walk_ph) : ccw_next(walk_ph);
            else if (roll < 52)
                walk_ph = ~walk_ph;
            else if (roll < 58)
                walk_ph = 2'($urandom_range(3));
            if ($urandom_range(99) < 5) sw_target = !sw_target;
            pin = ($urandom_range(99) < 4) ? !sw_target : sw_target;
            send_sample(walk_ph, pin, $urandom_range(99) < tick_pct);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn    <= 1'b1;
        s_idle_pct <= 32;
        m_idle_pct <= 80;
        @(negedge aclk);

        // Reset settings: step, step inside the gap, double jump, release without press,
        // then a level change held back by the debounce
        send_sample(2'd3, 1'b1, 1'b0);
        send_sample(2'd1, 1'b1, 1'b0);
        send_sample(2'd0, 1'b1, 1'b0);
        send_sample(2'd0, 1'b1, 1'b1);
        send_sample(2'd0, 1'b1, 1'b1);
        send_sample(2'd3, 1'b1, 1'b0);
        send_sample(2'd2, 1'b1, 1'b0);
        send_sample(2'd2, 1'b0, 1'b0);
        send_sample(2'd2, 1'b1, 1'b1);

        // Zero step size, no debounce, long press together with the press
        configure(16'd0, 5'd0, 16'd0, 16'd0, 1'b1);
        send_sample(2'd0, 1'b1, 1'b0);
        send_sample(2'd1, 1'b1, 1'b0);
        send_sample(2'd1, 1'b0, 1'b0);

        // Press on a low pin, sixteen steps per click
        configure(16'd0, 5'd16, 16'd1, 16'd0, 1'b0);
        send_sample(2'd0, 1'b0, 1'b0);
        send_sample(2'd1, 1'b1, 1'b0);
        send_sample(2'd1, 1'b0, 1'b0);
        send_sample(2'd1, 1'b0, 1'b1);
        send_sample(2'd1, 1'b0, 1'b1);
        send_sample(2'd1, 1'b1, 1'b0);

        // Widest step size in both directions
        configure(16'd0, 5'd31, 16'd1, 16'd0, 1'b1);
        send_sample(2'd0, 1'b1, 1'b0);
        send_sample(2'd1, 1'b1, 1'b0);
        send_sample(2'd3, 1'b1, 1'b1);
        send_sample(2'd1, 1'b0, 1'b0);

        configure(16'd0, 5'd1, 16'd3, 16'd0, 1'b1);
        random_samples(250, 50);
        configure(16'd1, 5'd5, 16'd8, 16'd2, 1'b0);
        random_samples(250, 70);

        s_idle_pct <= 80;
        m_idle_pct <= 32;
        configure(16'hFFFF, 5'd16, 16'hFFFF, 16'hFFFF, 1'b1);
        random_samples(80, 90);
        configure(16'd3, 5'd0, 16'd1, 16'd1, 1'b0);
        random_samples(250, 60);

        // No idling; hold the result side off long enough to back up the input
        s_idle_pct <= 0;
        m_idle_pct <= 0;
        configure(16'd2, 5'd7, 16'd12, 16'd5, 1'b1);
        hold_req <= 1'b1;
        random_samples(300, 80);

        wait_drained();
        $display("Checked %0d samples over %0d register settings: %0d step reports,",
                 checked_count, n_settings, step_count);
        $display("%0d presses, %0d long presses; input held off for %0d cycles.",
                 press_count, long_count, in_stalls);
        if (fail_count == 0)
            $display("** rotary_encoder_with_button_qualifier_top: PASSED **");
        else
            $display("** rotary_encoder_with_button_qualifier_top: FAILED **");
        $finish;
    end

endmodule
